// ===== sv/scd_pkg.sv =====
package scd_pkg;

    localparam int unsigned SecW   = 32;
    localparam int unsigned DaysW  = 16;
    localparam int unsigned RemW   = 17;
    localparam int unsigned YearW  = 8;
    localparam int unsigned MonW   = 4;
    localparam int unsigned DayW   = 5;
    localparam int unsigned HourW  = 5;
    localparam int unsigned MinW   = 6;
    localparam int unsigned SecFW  = 6;
    localparam int unsigned DoyW   = 9;

    localparam int unsigned SecPerDay  = 86400;
    localparam int unsigned SecPerHour = 3600;
    localparam int unsigned SecPerMin  = 60;
    localparam int unsigned DaysQuad   = 1461;
    localparam int unsigned DaysLeap   = 366;
    localparam int unsigned DaysCommon = 365;

    // 2100-03-01 as a day count; from here on a fake Feb 29 2100 is inserted
    // so every fourth year counts as leap
    localparam logic [DaysW-1:0] Skip2100 = 16'd36584;

    // reciprocals: q = (x * M) >> S, exact over the operand range
    localparam logic [25:0] RecipDay  = 26'd50903317;  // x / 675, x < 2^25
    localparam int unsigned ShDay     = 35;
    localparam logic [13:0] RecipHour = 14'd9321;      // x / 225, x < 2^13
    localparam int unsigned ShHour    = 21;
    localparam logic [10:0] RecipMin  = 11'd1093;      // x / 15, x < 2^10
    localparam int unsigned ShMin     = 14;
    localparam logic [16:0] RecipQuad = 17'd91868;     // x / 1461, x < 2^16
    localparam int unsigned ShQuad    = 27;

    localparam int unsigned Latency = 7;

    // first day of month within the year
    function automatic logic [DoyW-1:0] month_start(input logic leap, input logic [MonW-1:0] m);
        logic [DoyW-1:0] s;
        case (m)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && (m >= 4'd2)) begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

// ===== sv/scd_split.sv =====
// stages 1-2: day count and second of day
module scd_split (
    input  logic                        i_clk,
    input  logic [scd_pkg::SecW-1:0]    i_seconds_count,
    output logic [scd_pkg::RemW-1:0]    o_rem,
    output logic [scd_pkg::DaysW-1:0]   o_days_adj
);
    logic [scd_pkg::SecW-1:0]  r_t;
    logic [scd_pkg::DaysW-1:0] r_days;
    logic [scd_pkg::DaysW-1:0] n_days;
    logic [50:0]               w_pd;
    logic [32:0]               w_back;
    logic [scd_pkg::SecW-1:0]  w_rem;

    // t / 86400 == (t >> 7) / 675
    assign w_pd   = {26'd0, i_seconds_count[31:7]} * {25'd0, scd_pkg::RecipDay};
    assign n_days = w_pd[50:scd_pkg::ShDay];

    always_ff @(posedge i_clk) begin
        r_t    <= i_seconds_count;
        r_days <= n_days;
    end

    assign w_back = {17'd0, r_days} * 33'(scd_pkg::SecPerDay);
    assign w_rem  = r_t - w_back[31:0];

    always_ff @(posedge i_clk) begin
        o_rem      <= w_rem[scd_pkg::RemW-1:0];
        o_days_adj <= (r_days >= scd_pkg::Skip2100) ? r_days + 16'd1 : r_days;
    end
endmodule

// ===== sv/scd_tod.sv =====
// stages 3-7: hour, minute, second from the second of day
module scd_tod (
    input  logic                        i_clk,
    input  logic [scd_pkg::RemW-1:0]    i_rem,
    output logic [scd_pkg::HourW-1:0]   o_hour,
    output logic [scd_pkg::MinW-1:0]    o_minute,
    output logic [scd_pkg::SecFW-1:0]   o_second
);
    logic [scd_pkg::RemW-1:0]  r_rem3;
    logic [scd_pkg::HourW-1:0] r_hour3, r_hour4, r_hour5, r_hour6;
    logic [11:0]               r_rem4, r_rem5;
    logic [scd_pkg::MinW-1:0]  r_min5, r_min6;
    logic [scd_pkg::SecFW-1:0] r_sec6;
    logic [26:0]               w_ph;
    logic [16:0]               w_hb;
    logic [20:0]               w_pm;
    logic [11:0]               w_mb;

    // rem / 3600 == (rem >> 4) / 225
    assign w_ph = {14'd0, i_rem[16:4]} * {13'd0, scd_pkg::RecipHour};
    always_ff @(posedge i_clk) begin
        r_rem3  <= i_rem;
        r_hour3 <= w_ph[25:scd_pkg::ShHour];
    end

    assign w_hb = {12'd0, r_hour3} * 17'(scd_pkg::SecPerHour);
    always_ff @(posedge i_clk) begin
        r_rem4  <= 12'(r_rem3 - w_hb);
        r_hour4 <= r_hour3;
    end

    // rem / 60 == (rem >> 2) / 15
    assign w_pm = {11'd0, r_rem4[11:2]} * {10'd0, scd_pkg::RecipMin};
    always_ff @(posedge i_clk) begin
        r_rem5  <= r_rem4;
        r_min5  <= w_pm[19:scd_pkg::ShMin];
        r_hour5 <= r_hour4;
    end

    assign w_mb = {6'd0, r_min5} * 12'(scd_pkg::SecPerMin);
    always_ff @(posedge i_clk) begin
        r_sec6  <= 6'(r_rem5 - w_mb);
        r_min6  <= r_min5;
        r_hour6 <= r_hour5;
    end

    always_ff @(posedge i_clk) begin
        o_hour   <= r_hour6;
        o_minute <= r_min6;
        o_second <= r_sec6;
    end
endmodule

// ===== sv/scd_date.sv =====
// stages 3-7: year, month, day from the adjusted day count
module scd_date (
    input  logic                        i_clk,
    input  logic [scd_pkg::DaysW-1:0]   i_days_adj,
    output logic [scd_pkg::YearW-1:0]   o_year,
    output logic [scd_pkg::MonW-1:0]    o_month,
    output logic [scd_pkg::DayW-1:0]    o_day
);
    logic [scd_pkg::DaysW-1:0] r_dp3;
    logic [5:0]                r_q3, r_q4, r_q5;
    logic [10:0]               r_r4;
    logic [1:0]                r_yin5;
    logic [scd_pkg::DoyW-1:0]  r_doy5, r_doy6;
    logic [scd_pkg::YearW-1:0] r_year6;
    logic                      r_leap6;
    logic [scd_pkg::MonW-1:0]  r_mon6;
    logic                      r_leap5;
    logic [32:0]               w_pq;
    logic [16:0]               w_qb;
    logic [10:0]               w_s;
    logic [1:0]                n_yin;
    logic [10:0]               n_doy;
    logic [scd_pkg::MonW-1:0]  n_mon;

    assign w_pq = {17'd0, i_days_adj} * {16'd0, scd_pkg::RecipQuad};
    always_ff @(posedge i_clk) begin
        r_dp3 <= i_days_adj;
        r_q3  <= w_pq[32:scd_pkg::ShQuad];
    end

    assign w_qb = {11'd0, r_q3} * 17'(scd_pkg::DaysQuad);
    always_ff @(posedge i_clk) begin
        r_r4 <= 11'(r_dp3 - w_qb[15:0]);
        r_q4 <= r_q3;
    end

    // first year of each four-year group has 366 days
    assign w_s = r_r4 - 11'(scd_pkg::DaysLeap);
    always_comb begin
        if (r_r4 < 11'(scd_pkg::DaysLeap)) begin
            n_yin = 2'd0;
            n_doy = r_r4;
        end else if (w_s < 11'(scd_pkg::DaysCommon)) begin
            n_yin = 2'd1;
            n_doy = w_s;
        end else if (w_s < 11'(2 * scd_pkg::DaysCommon)) begin
            n_yin = 2'd2;
            n_doy = w_s - 11'(scd_pkg::DaysCommon);
        end else begin
            n_yin = 2'd3;
            n_doy = w_s - 11'(2 * scd_pkg::DaysCommon);
        end
    end

    always_ff @(posedge i_clk) begin
        r_q5    <= r_q4;
        r_yin5  <= n_yin;
        r_doy5  <= n_doy[scd_pkg::DoyW-1:0];
        r_leap5 <= (n_yin == 2'd0);
    end

    always_comb begin
        n_mon = '0;
        for (int k = 1; k < 12; k++) begin
            if (r_doy5 >= scd_pkg::month_start(r_leap5, 4'(k))) begin
                n_mon = 4'(k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year6 <= {r_q5, r_yin5};
        r_mon6  <= n_mon;
        r_doy6  <= r_doy5;
        r_leap6 <= r_leap5;
    end

    always_ff @(posedge i_clk) begin
        o_year  <= r_year6;
        o_month <= r_mon6;
        o_day   <= 5'(r_doy6 - scd_pkg::month_start(r_leap6, r_mon6));
    end
endmodule

// ===== sv/seconds_to_calendar_date_top.sv =====
// Channel   Direction  Handshake              Payload
// command   in         i_start, o_busy        i_seconds_count
// result    out        o_valid (one cycle)    o_year_offset .. o_second_of_minute
//
// Seven register stages lie between a start beat and its result.
// A new beat may enter every cycle; o_busy is never raised.
// Depth is set by the constant multiplies: at most one sits in any stage's path.
// Reset (synchronous, active low) clears only the valid chain.
// The receiver cannot stall: each result is shown for exactly one cycle.
module seconds_to_calendar_date_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [scd_pkg::SecW-1:0]    i_seconds_count,
    output logic                        o_valid,
    output logic [scd_pkg::YearW-1:0]   o_year_offset,
    output logic [scd_pkg::MonW-1:0]    o_month_index,
    output logic [scd_pkg::DayW-1:0]    o_day_index,
    output logic [scd_pkg::HourW-1:0]   o_hour_of_day,
    output logic [scd_pkg::MinW-1:0]    o_minute_of_hour,
    output logic [scd_pkg::SecFW-1:0]   o_second_of_minute
);
    logic [scd_pkg::Latency-1:0] r_vld;
    logic [scd_pkg::Latency-1:0] n_vld;
    logic [scd_pkg::RemW-1:0]    w_rem;
    logic [scd_pkg::DaysW-1:0]   w_days_adj;

    assign o_busy = 1'b0;

    // valid bits travel alongside the payload stages
    assign n_vld = {r_vld[scd_pkg::Latency-2:0], i_start & ~o_busy};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end
    assign o_valid = r_vld[scd_pkg::Latency-1];

    scd_split u_split (
        .i_clk           (i_clk),
        .i_seconds_count (i_seconds_count),
        .o_rem           (w_rem),
        .o_days_adj      (w_days_adj)
    );

    scd_tod u_tod (
        .i_clk    (i_clk),
        .i_rem    (w_rem),
        .o_hour   (o_hour_of_day),
        .o_minute (o_minute_of_hour),
        .o_second (o_second_of_minute)
    );

    scd_date u_date (
        .i_clk      (i_clk),
        .i_days_adj (w_days_adj),
        .o_year     (o_year_offset),
        .o_month    (o_month_index),
        .o_day      (o_day_index)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 7))
        else $error("result without start beat");
    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_year_offset <= 8'd136 && o_month_index <= 4'd11 && o_day_index <= 5'd30))
        else $error("date out of range");
    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hour_of_day <= 5'd23 && o_minute_of_hour <= 6'd59
                     && o_second_of_minute <= 6'd59))
        else $error("time out of range");
`endif
endmodule
